FILE: sv/base91_fixed13_encoder_top_defines.svh
// Assertion macros shared by the base91 fixed-width encoder RTL.
// Included by every module that carries concurrent assertions; depends on nothing.
`ifndef BASE91_FIXED13_ENCODER_TOP_DEFINES_SVH
`define BASE91_FIXED13_ENCODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on the rising edge outside reset.
`define B91_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Next-cycle implication, checked on the rising edge outside reset.
`define B91_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define B91_ASSERT(label, clk, rst_n, prop, msg)
`define B91_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

FILE: sv/b91f13_pkg.sv
// Package for the base91 fixed-width encoder: constants, command type and alphabet.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package b91f13_pkg;

    localparam int unsigned SymBase    = 91;
    localparam int unsigned WordBits   = 13;
    localparam int unsigned ByteBits   = 8;
    localparam int unsigned PendBits   = 12;
    localparam int unsigned CntW       = 4;
    localparam int unsigned IdxW       = 7;
    localparam int unsigned TailTwoMin = 7;
    // A data byte completes a word once this many bits were already pending.
    localparam int unsigned FullFrom   = WordBits - ByteBits;
    localparam int unsigned ExtBits    = PendBits + ByteBits;
    // Reciprocal of 91 scaled by 2^16; the estimate is exact or one low.
    localparam int unsigned RecipMul   = 720;
    localparam int unsigned RecipShift = 16;
    localparam int unsigned RecipW     = 10;
    localparam int unsigned ProdW      = WordBits + RecipW;
    localparam int unsigned QueueDepth = 2;

    // Input kind codes carried on tuser.
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef logic [WordBits-1:0] t_word;
    typedef logic [IdxW-1:0]     t_idx;

    // One encode job handed from the front to the back.
    typedef struct packed {
        t_word word;
        logic  two;
        logic  fin;
    } t_cmd;

    localparam logic [6:0] ALPHABET [0:SymBase-1] = '{
        7'h21, 7'h7E, 7'h7D, 7'h7C, 7'h7B, 7'h7A, 7'h79, 7'h78, 7'h77, 7'h76,
        7'h75, 7'h74, 7'h73, 7'h72, 7'h71, 7'h70, 7'h6F, 7'h6E, 7'h6D, 7'h6C,
        7'h6B, 7'h6A, 7'h69, 7'h68, 7'h67, 7'h66, 7'h65, 7'h64, 7'h63, 7'h62,
        7'h61, 7'h60, 7'h5F, 7'h5E, 7'h5D, 7'h23, 7'h5B, 7'h5A, 7'h59, 7'h58,
        7'h57, 7'h56, 7'h55, 7'h54, 7'h53, 7'h52, 7'h51, 7'h50, 7'h4F, 7'h4E,
        7'h4D, 7'h4C, 7'h4B, 7'h4A, 7'h49, 7'h48, 7'h47, 7'h46, 7'h45, 7'h44,
        7'h43, 7'h42, 7'h41, 7'h40, 7'h3F, 7'h3E, 7'h3D, 7'h3C, 7'h3B, 7'h3A,
        7'h39, 7'h38, 7'h37, 7'h36, 7'h35, 7'h34, 7'h33, 7'h32, 7'h31, 7'h30,
        7'h2F, 7'h2E, 7'h2D, 7'h2C, 7'h2B, 7'h2A, 7'h29, 7'h28, 7'h24, 7'h26,
        7'h25
    };

    // Alphabet lookup; indices beyond the table give zero.
    function automatic logic [6:0] f_alphabet(input t_idx idx);
        logic [6:0] sym;
        sym = 7'h00;
        if (idx < IdxW'(SymBase)) begin
            sym = ALPHABET[idx];
        end
        return sym;
    endfunction

endpackage

`default_nettype wire

FILE: sv/b91f13_front.sv
// Front part of the encoder: accepts input items and runs the bit collector.
// Depends on b91f13_pkg; emits encode jobs into the queue.
`default_nettype none
`include "base91_fixed13_encoder_top_defines.svh"

module b91f13_front
    import b91f13_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire logic i_kind,
    input  wire logic [ByteBits-1:0] i_byte,
    input  wire logic i_full,
    output logic      o_push,
    output t_cmd      o_cmd
);

    logic [PendBits-1:0] r_bits, n_bits;
    logic [CntW-1:0]     r_cnt,  n_cnt;
    logic [ExtBits-1:0]  w_ext;
    logic                w_accept;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;

    // New byte lands above the pending bits, least significant bit first.
    assign w_ext = {{ByteBits{1'b0}}, r_bits} |
                   ({{PendBits{1'b0}}, i_byte} << r_cnt);

    // Classify the transaction and work out the next collector state.
    always_comb begin
        n_bits = r_bits;
        n_cnt  = r_cnt;
        o_push = 1'b0;
        o_cmd  = '{word: w_ext[WordBits-1:0], two: 1'b1, fin: 1'b0};
        if (w_accept) begin
            unique case (i_kind)
                KIND_DATA: begin
                    if (r_cnt >= CntW'(FullFrom)) begin
                        o_push = 1'b1;
                        n_bits = PendBits'(w_ext[ExtBits-1:WordBits]);
                        n_cnt  = r_cnt - CntW'(FullFrom);
                    end else begin
                        n_bits = w_ext[PendBits-1:0];
                        n_cnt  = r_cnt + CntW'(ByteBits);
                    end
                end
                KIND_FINISH: begin
                    o_push = (r_cnt != '0);
                    o_cmd  = '{word: WordBits'(r_bits),
                               two:  (r_cnt >= CntW'(TailTwoMin)),
                               fin:  1'b1};
                    n_bits = '0;
                    n_cnt  = '0;
                end
                default: begin
                    n_bits = r_bits;
                    n_cnt  = r_cnt;
                end
            endcase
        end
    end

    // Collector registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_cnt  <= '0;
        end else begin
            r_bits <= n_bits;
            r_cnt  <= n_cnt;
        end
    end

    `B91_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= CntW'(PendBits), "pending count above 12")
    `B91_ASSERT_NEXT(a_finish_clears, i_clk, i_rst_n, w_accept && i_kind == KIND_FINISH, r_cnt == '0 && r_bits == '0, "finish did not clear the collector")

endmodule

`default_nettype wire

FILE: sv/b91f13_fifo.sv
// Short queue of encode jobs between the front and the back of the encoder.
// Depends on b91f13_pkg for the job type and depth.
`default_nettype none
`include "base91_fixed13_encoder_top_defines.svh"

module b91f13_fifo
    import b91f13_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_cmd      o_cmd
);

    localparam int unsigned PtrW = $clog2(QueueDepth);
    localparam int unsigned CntQ = $clog2(QueueDepth + 1);

    t_cmd              r_mem [0:QueueDepth-1];
    logic [PtrW-1:0]   r_wr, r_rd;
    logic [CntQ-1:0]   r_count;
    logic              w_push, w_pop;

    assign o_full  = (r_count == CntQ'(QueueDepth));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PtrW'(QueueDepth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PtrW'(QueueDepth - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CntQ'(w_push) - CntQ'(w_pop);
        end
    end

    `B91_ASSERT(a_no_push_full, i_clk, i_rst_n, !(i_push && o_full), "job pushed into a full queue")

endmodule

`default_nettype wire

FILE: sv/b91f13_back.sv
// Back part of the encoder: splits each 13-bit word by 91 and sends the symbols.
// Depends on b91f13_pkg for the job type, reciprocal constants and alphabet.
`default_nettype none
`include "base91_fixed13_encoder_top_defines.svh"

module b91f13_back
    import b91f13_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_ready,
    output logic [6:0] o_symbol,
    output logic      o_last,
    output logic      o_end
);

    localparam int unsigned RemW = IdxW + 1;

    // Divide stage: job plus quotient estimate.
    logic                r_s1_valid;
    t_cmd                r_s1_cmd;
    t_idx                r_s1_q0;
    // Output stage: remainder, quotient and which one is on the port.
    logic                r_s2_valid;
    t_idx                r_rem, r_quot;
    logic                r_two, r_fin, r_phase;

    logic [ProdW-1:0]    w_prod;
    t_word               w_qmul;
    logic [RemW-1:0]     w_r0;
    logic                w_fix;
    logic                w_last, w_s2_free, w_s1_adv;

    assign w_last    = r_phase || !r_two;
    assign w_s2_free = !r_s2_valid || (i_ready && w_last);
    assign w_s1_adv  = r_s1_valid && w_s2_free;
    assign o_pop     = i_valid && (!r_s1_valid || w_s2_free);

    // Quotient estimate by reciprocal multiplication.
    assign w_prod = ProdW'(i_cmd.word) * ProdW'(RecipMul);

    // Remainder from the estimate, then one correction step.
    assign w_qmul = WordBits'(r_s1_q0) * WordBits'(SymBase);
    assign w_r0   = RemW'(r_s1_cmd.word - w_qmul);
    assign w_fix  = (w_r0 >= RemW'(SymBase));

    // Divide stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_pop) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_cmd <= i_cmd;
            r_s1_q0  <= w_prod[ProdW-1:RecipShift];
        end
    end

    // Output stage control: first the remainder symbol, then the quotient.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_phase    <= 1'b0;
        end else if (w_s1_adv) begin
            r_s2_valid <= 1'b1;
            r_phase    <= 1'b0;
        end else if (r_s2_valid && i_ready) begin
            if (w_last) begin
                r_s2_valid <= 1'b0;
                r_phase    <= 1'b0;
            end else begin
                r_phase <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_rem  <= w_fix ? IdxW'(w_r0 - RemW'(SymBase)) : IdxW'(w_r0);
            r_quot <= w_fix ? r_s1_q0 + 1'b1 : r_s1_q0;
            r_two  <= r_s1_cmd.two;
            r_fin  <= r_s1_cmd.fin;
        end
    end

    assign o_valid  = r_s2_valid;
    assign o_symbol = f_alphabet(r_phase ? r_quot : r_rem);
    assign o_last   = w_last;
    assign o_end    = r_fin && w_last;

    `B91_ASSERT(a_idx_range, i_clk, i_rst_n, !r_s2_valid || (r_rem < IdxW'(SymBase) && r_quot < IdxW'(SymBase)), "symbol index outside the alphabet")
    `B91_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !w_s2_free, r_s1_valid && $stable(r_s1_cmd), "divide stage lost a waiting job")

endmodule

`default_nettype wire

FILE: sv/base91_fixed13_encoder_top.sv
// Top level of the base91 encoder with fixed 13-bit words.
// Depends on b91f13_pkg, b91f13_front, b91f13_fifo and b91f13_back.
//
//   Channel  | Direction | tdata (low bit up)    | tuser         | tlast
//   s_axis   | in        | data_byte[7:0]        | kind          | -
//   m_axis   | out       | symbol[6:0], zero bit | message_end   | last_of_run
//
// A data byte that completes no word yields no symbol; one that completes a
// word, or a finish with seven or more bits pending, yields two symbols, sent
// one at a time by the single-symbol output register; new items are still
// taken while the queue has room, before the last item's symbols are sent.
// The first symbol appears once the job has passed the queue entry written at
// the accepting edge, then the divide stage, then the output stage.
// Reset is synchronous and clears the collector, the queue and both stages.
// Output stalls back up through the two-entry queue.
`default_nettype none

module base91_fixed13_encoder_top
    import b91f13_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic       s_axis_tuser,   // [0] kind
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [6:0] symbol, [7] zero
    output logic            m_axis_tlast,
    output logic            m_axis_tuser    // [0] message_end
);

    logic       w_push, w_full, w_q_valid, w_pop;
    t_cmd       w_push_cmd, w_head_cmd;
    logic [6:0] w_symbol;

    b91f13_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_kind  (s_axis_tuser),
        .i_byte  (s_axis_tdata),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    b91f13_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd)
    );

    b91f13_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_cmd    (w_head_cmd),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_symbol (w_symbol),
        .o_last   (m_axis_tlast),
        .o_end    (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, w_symbol};

endmodule

`default_nettype wire
